/* sv/rvis_pkg.sv */
// shared types and constants for the instruction-step core
package rvis_pkg;

  localparam int unsigned MemDepth   = 4096;
  localparam int unsigned MemAw      = $clog2(MemDepth);
  localparam int unsigned StackDepth = 16;
  localparam int unsigned SpW        = $clog2(StackDepth);
  localparam int unsigned FontLen    = 80;
  localparam int unsigned FontAw     = $clog2(FontLen);

  localparam logic [11:0] PcReset = 12'h200;
  localparam logic [15:0] OpCls   = 16'h00E0;
  localparam logic [15:0] OpRet   = 16'h00EE;

  typedef enum logic [1:0] {
    FuncMemWr = 2'd0,
    FuncExec  = 2'd1,
    FuncMemRd = 2'd2,
    FuncRegRd = 2'd3
  } func_e;

  // top nibble of the instruction word
  typedef enum logic [3:0] {
    GrpSys     = 4'h0,
    GrpJump    = 4'h1,
    GrpCall    = 4'h2,
    GrpSkipEq  = 4'h3,
    GrpSkipNe  = 4'h4,
    GrpSkipReg = 4'h5,
    GrpLoad    = 4'h6,
    GrpAdd     = 4'h7
  } grp_e;

  typedef struct packed {
    func_e       func;
    logic [11:0] addr;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [11:0] prog_counter;
    logic [15:0] last_opcode;
    logic [7:0]  read_data;
    logic        screen_clear;
    logic        unknown_op;
  } out_item_t;

  localparam logic [7:0] FontRom [FontLen] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

endpackage

/* sv/retro_vm_instruction_step.sv */
// instruction-step core: program memory, register file, return stack and pc
// an input transfer registers into stage one, then stage two, then the output register
// throughput: memory and register accesses one per cycle unless the output stalls;
//   an execute waits for its fetch address, the pc that an earlier one resolves in stage two
// reset: after rst_ni rises a pass over all 4096 bytes loads the font and zeros into the
//   program memory, one byte a cycle, with input stalled; registers and stack read zero
module retro_vm_instruction_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rvis_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rvis_pkg::out_item_t out_item_o
);
  import rvis_pkg::*;

  // program memory and its clearing pass
  logic [7:0]       pmem [MemDepth];
  logic             clr_busy_q;
  logic [MemAw-1:0] clr_cnt_q;
  logic [7:0]       font_b;

  // pipeline control
  logic             s1_valid_q, s2_valid_q, out_valid_q;
  func_e            s1_func_q, s2_func_q;
  logic [3:0]       s1_ridx_q;
  logic             mv_x, mv_d, room, hazard, acc;
  logic             s1_exec, s2_exec, in_exec;

  // memory read data (stage one)
  logic [7:0]       mrd0_q, mrd1_q;
  logic [MemAw-1:0] mra0, mra1, mwa;
  logic [7:0]       mwd;
  logic             mwe;
  logic [11:0]      pc_fetch;
  logic [15:0]      s1_op;

  // register file, read in stage one, written when an item leaves stage two
  logic [7:0]       rf [16];
  logic [15:0]      rf_vld_q;
  logic [3:0]       rf_ra0, rf_ra1, rf_wa;
  logic [7:0]       rf_wd;
  logic             rf_we;
  logic [7:0]       rf_rd0_q, rf_rd1_q, fwd_data_q;
  logic             rf_v0_q, rf_v1_q, fwd0_q, fwd1_q;
  logic [7:0]       x_val, y_val;

  // stage two payload
  logic [15:0]      s2_op_q;
  logic [7:0]       s2_mem_q;

  // architectural state
  logic [11:0]      pc_q, pc_next;
  logic [15:0]      opc_q;
  logic [SpW-1:0]   sp_q, sp_next, sp_inc, sp_dec;
  logic [11:0]      stack_q [StackDepth];
  logic             push;
  logic             clr_flag, unk_flag;
  logic [7:0]       nn;
  logic [11:0]      pc_p2, pc_p4;
  logic [7:0]       rd_sel;

  out_item_t        out_q, res;

  assign s1_exec = (s1_func_q == FuncExec);
  assign s2_exec = (s2_func_q == FuncExec);
  assign in_exec = (in_item_i.func == FuncExec);

  // elastic stages: each moves when the one ahead is empty or moving
  assign mv_x = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign mv_d = s1_valid_q && (!s2_valid_q || mv_x);
  assign room = !s1_valid_q || mv_d;

  // an execute waits until the pc of an earlier execute is known in stage two
  assign hazard = in_exec && ((s1_valid_q && s1_exec) || (s2_valid_q && s2_exec && !mv_x));

  assign in_stall_o = clr_busy_q || !room || hazard;
  assign acc        = in_valid_i && !in_stall_o;

  // fetch address bypasses the pc of an execute that leaves stage two this cycle
  assign pc_fetch = (s2_valid_q && s2_exec) ? pc_next : pc_q;

  // ---------------------------------------------------------------- program memory
  assign font_b = (clr_cnt_q < MemAw'(FontLen)) ? FontRom[clr_cnt_q[FontAw-1:0]] : 8'h00;

  assign mwe  = clr_busy_q || (acc && (in_item_i.func == FuncMemWr));
  assign mwa  = clr_busy_q ? clr_cnt_q : in_item_i.addr[MemAw-1:0];
  assign mwd  = clr_busy_q ? font_b : in_item_i.data;
  assign mra0 = in_exec ? pc_fetch[MemAw-1:0] : in_item_i.addr[MemAw-1:0];
  assign mra1 = MemAw'(pc_fetch + 12'd1);

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      pmem[mwa] <= mwd;
    end
    if (acc) begin
      mrd0_q <= pmem[mra0];
      mrd1_q <= pmem[mra1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + MemAw'(1);
      if (clr_cnt_q == MemAw'(MemDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stage one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_func_q  <= FuncMemWr;
      s1_ridx_q  <= '0;
    end else if (room) begin
      s1_valid_q <= acc;
      if (acc) begin
        s1_func_q <= in_item_i.func;
        s1_ridx_q <= in_item_i.addr[3:0];
      end
    end
  end

  assign s1_op  = {mrd0_q, mrd1_q};
  assign rf_ra0 = s1_exec ? s1_op[11:8] : s1_ridx_q;
  assign rf_ra1 = s1_op[7:4];

  // register file array, no reset: the valid bits stand in for the zero reset
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (mv_d) begin
      rf_rd0_q   <= rf[rf_ra0];
      rf_rd1_q   <= rf[rf_ra1];
      fwd_data_q <= rf_wd;
      s2_op_q    <= s1_op;
      s2_mem_q   <= mrd0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q   <= '0;
      rf_v0_q    <= 1'b0;
      rf_v1_q    <= 1'b0;
      fwd0_q     <= 1'b0;
      fwd1_q     <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_func_q  <= FuncMemWr;
    end else begin
      if (rf_we) begin
        rf_vld_q[rf_wa] <= 1'b1;
      end
      if (mv_d) begin
        rf_v0_q   <= rf_vld_q[rf_ra0];
        rf_v1_q   <= rf_vld_q[rf_ra1];
        // write by the item just ahead lands in the same cycle as this read
        fwd0_q    <= rf_we && (rf_wa == rf_ra0);
        fwd1_q    <= rf_we && (rf_wa == rf_ra1);
        s2_func_q <= s1_func_q;
      end
      if (mv_d) begin
        s2_valid_q <= 1'b1;
      end else if (mv_x) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stage two
  assign x_val = fwd0_q ? fwd_data_q : (rf_v0_q ? rf_rd0_q : 8'h00);
  assign y_val = fwd1_q ? fwd_data_q : (rf_v1_q ? rf_rd1_q : 8'h00);

  assign nn     = s2_op_q[7:0];
  assign pc_p2  = pc_q + 12'd2;
  assign pc_p4  = pc_q + 12'd4;
  assign sp_inc = (sp_q == SpW'(StackDepth - 1)) ? '0 : sp_q + SpW'(1);
  assign sp_dec = (sp_q == '0) ? SpW'(StackDepth - 1) : sp_q - SpW'(1);

  always_comb begin
    pc_next  = pc_q;
    sp_next  = sp_q;
    push     = 1'b0;
    clr_flag = 1'b0;
    unk_flag = 1'b0;
    rf_wd    = nn;
    rf_wa    = s2_op_q[11:8];
    rf_we    = 1'b0;
    case (grp_e'(s2_op_q[15:12]))
      GrpSys: begin
        if (s2_op_q == OpCls) begin
          clr_flag = 1'b1;
          pc_next  = pc_p2;
        end else if (s2_op_q == OpRet) begin
          sp_next = sp_dec;
          pc_next = stack_q[sp_dec] + 12'd2;
        end else begin
          unk_flag = 1'b1;
        end
      end
      GrpJump: begin
        pc_next = s2_op_q[11:0];
      end
      GrpCall: begin
        push    = 1'b1;
        sp_next = sp_inc;
        pc_next = s2_op_q[11:0];
      end
      GrpSkipEq: begin
        pc_next = (x_val == nn) ? pc_p4 : pc_p2;
      end
      GrpSkipNe: begin
        pc_next = (x_val != nn) ? pc_p4 : pc_p2;
      end
      GrpSkipReg: begin
        pc_next = (x_val == y_val) ? pc_p4 : pc_p2;
      end
      GrpLoad: begin
        rf_we   = 1'b1;
        pc_next = pc_p2;
      end
      GrpAdd: begin
        rf_we   = 1'b1;
        rf_wd   = x_val + nn;
        pc_next = pc_p2;
      end
      default: begin
        unk_flag = 1'b1;
      end
    endcase
    // only an execute leaving stage two commits anything
    if (!(mv_x && s2_exec)) begin
      rf_we = 1'b0;
    end
  end

  always_comb begin
    case (s2_func_q)
      FuncMemRd: rd_sel = s2_mem_q;
      FuncRegRd: rd_sel = x_val;
      default:   rd_sel = 8'h00;
    endcase
  end

  always_comb begin
    res.prog_counter = s2_exec ? pc_next : pc_q;
    res.last_opcode  = s2_exec ? s2_op_q : opc_q;
    res.read_data    = rd_sel;
    res.screen_clear = s2_exec && clr_flag;
    res.unknown_op   = s2_exec && unk_flag;
  end

  // architectural state commits as an execute leaves stage two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PcReset;
      opc_q   <= '0;
      sp_q    <= '0;
      stack_q <= '{default: '0};
    end else if (mv_x && s2_exec) begin
      pc_q  <= pc_next;
      opc_q <= s2_op_q;
      sp_q  <= sp_next;
      if (push) begin
        stack_q[sp_q] <= pc_q;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mv_x) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv_x) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------- assertions
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !acc)
    else $error("input transfer during memory clearing pass");

  a_single_exec_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && s1_exec && s2_valid_q && s2_exec))
    else $error("two execute items in flight");

  a_pc_only_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mv_x && s2_exec) |=> $stable(pc_q))
    else $error("pc changed without an execute commit");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.screen_clear && out_q.unknown_op))
    else $error("clear and unknown flagged together");

  a_exec_fetch_pc_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_exec) |-> !(s2_valid_q && s2_exec && !mv_x))
    else $error("execute fetched before previous pc was resolved");

endmodule

/* bench/retro_vm_instruction_step_tb.sv */
// self-checking testbench for the instruction-step core, with its own predictor
`timescale 1ns / 1ps

module retro_vm_instruction_step_tb;
  import rvis_pkg::*;

  localparam int unsigned RandItems   = 2000;
  localparam int unsigned LimitCycles = 500000;
  localparam int unsigned TailCycles  = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // stimulus side
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      in_stall;

  // result side
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  retro_vm_instruction_step dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #4 clk = ~clk;

  // one reset at the start, released on a rising edge
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // machine state as the predictor sees it, updated on each input transfer
  // ---------------------------------------------------------------------------
  logic [7:0]  vm_mem   [MemDepth];
  logic [7:0]  vm_regs  [16];
  logic [11:0] vm_stack [StackDepth];
  logic [3:0]  vm_sp;
  logic [11:0] vm_pc;
  logic [15:0] vm_op;

  in_item_t  cmd_q[$];         // items waiting for the driver
  out_item_t vm_results_q[$];  // results the core owes us, oldest first

  int n_pushed   = 0;
  int n_accepted = 0;
  int n_errors   = 0;
  int n_cycles   = 0;

  function automatic void vm_reset();
    for (int i = 0; i < MemDepth; i++) vm_mem[i] = (i < FontLen) ? FontRom[i] : 8'h00;
    for (int i = 0; i < 16; i++) vm_regs[i] = 8'h00;
    for (int i = 0; i < StackDepth; i++) vm_stack[i] = 12'h000;
    vm_sp = '0;
    vm_pc = PcReset;
    vm_op = 16'h0000;
  endfunction

  // applies one item to the machine state and returns the result it must give
  function automatic out_item_t vm_step(in_item_t it);
    out_item_t   res;
    logic [15:0] op;
    logic [11:0] pc;
    logic [3:0]  x;
    logic [7:0]  nn;
    res = '0;
    case (it.func)
      FuncMemWr: vm_mem[it.addr] = it.data;
      FuncMemRd: res.read_data = vm_mem[it.addr];
      FuncRegRd: res.read_data = vm_regs[it.addr[3:0]];
      default: begin
        // big-endian fetch, the second byte address wraps past the top
        pc = vm_pc;
        op = {vm_mem[pc], vm_mem[pc + 12'd1]};
        vm_op = op;
        x = op[11:8];
        nn = op[7:0];
        case (op[15:12])
          GrpSys: begin
            if (op == OpCls) begin
              res.screen_clear = 1'b1;
              pc = pc + 12'd2;
            end else if (op == OpRet) begin
              // pop first, then skip past the call that pushed the entry
              vm_sp = vm_sp - 4'd1;
              pc = vm_stack[vm_sp] + 12'd2;
            end else begin
              res.unknown_op = 1'b1;
            end
          end
          GrpJump: pc = op[11:0];
          GrpCall: begin
            vm_stack[vm_sp] = pc;
            vm_sp = vm_sp + 4'd1;
            pc = op[11:0];
          end
          GrpSkipEq:  pc = pc + ((vm_regs[x] == nn) ? 12'd4 : 12'd2);
          GrpSkipNe:  pc = pc + ((vm_regs[x] != nn) ? 12'd4 : 12'd2);
          // low nibble of the register skip is a don't-care
          GrpSkipReg: pc = pc + ((vm_regs[x] == vm_regs[op[7:4]]) ? 12'd4 : 12'd2);
          GrpLoad: begin
            vm_regs[x] = nn;
            pc = pc + 12'd2;
          end
          GrpAdd: begin
            vm_regs[x] = vm_regs[x] + nn;
            pc = pc + 12'd2;
          end
          default: res.unknown_op = 1'b1;
        endcase
        vm_pc = pc;
      end
    endcase
    res.prog_counter = vm_pc;
    res.last_opcode = vm_op;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_error(input string msg);
    $display("%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s mismatch: got %h, want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of transfers separated by random gaps
  // ---------------------------------------------------------------------------
  int gap_left   = 0;
  int burst_left = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      // predictor runs before the counter moves, so planners see it up to date
      if (in_valid && !in_stall) begin
        vm_results_q.push_back(vm_step(in_item));
        n_accepted++;
      end
      // a stalled item stays put; otherwise load the next one or go idle
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || cmd_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          in_valid <= 1'b1;
          in_item <= cmd_q.pop_front();
          if (burst_left != 0) begin
            burst_left <= burst_left - 1;
          end else begin
            // about a third of bursts run straight into the next one
            burst_left <= $urandom_range(0, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transfer, stalls in phases of varying density
  // ---------------------------------------------------------------------------
  out_item_t due;
  int        stall_mode = 0;
  int        phase_left = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      phase_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (vm_results_q.size() == 0) begin
          report_error("result transfer with nothing expected");
        end else begin
          due = vm_results_q.pop_front();
          check_field("prog_counter", 16'(out_item.prog_counter), 16'(due.prog_counter));
          check_field("last_opcode", out_item.last_opcode, due.last_opcode);
          check_field("read_data", 16'(out_item.read_data), 16'(due.read_data));
          check_field("screen_clear", 16'(out_item.screen_clear), 16'(due.screen_clear));
          check_field("unknown_op", 16'(out_item.unknown_op), 16'(due.unknown_op));
        end
      end
      if (phase_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        phase_left <= $urandom_range(16, 200);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;                            // free running
        1: out_stall <= ($urandom_range(0, 3) == 0);     // light back-pressure
        2: out_stall <= ($urandom_range(0, 3) != 0);     // heavy back-pressure
        default: out_stall <= n_cycles[2];               // regular on/off
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= LimitCycles) begin
      $display("retro_vm_instruction_step_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus planning
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input func_e f, input logic [11:0] a, input logic [7:0] d);
    in_item_t it;
    it.func = f;
    it.addr = a;
    it.data = d;
    cmd_q.push_back(it);
    n_pushed++;
  endtask

  // block until every planned item has gone through the predictor, so that
  // vm_pc and vm_regs reflect the core's state when the next chunk is planned
  task automatic settle();
    while (n_accepted != n_pushed) @(posedge clk);
  endtask

  task automatic write_op(input logic [11:0] wa, input logic [15:0] op);
    push_cmd(FuncMemWr, wa, op[15:8]);
    push_cmd(FuncMemWr, wa + 12'd1, op[7:0]);
  endtask

  // place one instruction at the current pc and execute it
  task automatic run_op(input logic [15:0] op);
    settle();
    write_op(vm_pc, op);
    push_cmd(FuncExec, 12'($urandom), 8'($urandom));
  endtask

  function automatic logic [11:0] rand_target();
    case ($urandom_range(0, 3))
      0: return 12'($urandom);
      1: return PcReset + 12'($urandom_range(0, 255));
      2: return vm_pc + 12'($urandom_range(0, 16));
      default: return ($urandom_range(0, 1) == 0) ? 12'hFFE : 12'hFFF;
    endcase
  endfunction

  // weighted towards the implemented opcodes, immediates often matching a register
  function automatic logic [15:0] rand_op();
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] nn;
    x = 4'($urandom);
    y = ($urandom_range(0, 3) == 0) ? x : 4'($urandom);
    nn = ($urandom_range(0, 2) == 0) ? vm_regs[x] : 8'($urandom);
    case ($urandom_range(0, 13))
      0: return OpCls;
      1: return OpRet;
      2: return {GrpJump, rand_target()};
      3: return {GrpCall, rand_target()};
      4: return {GrpSkipEq, x, nn};
      5: return {GrpSkipNe, x, nn};
      6: return {GrpSkipReg, x, y, 4'($urandom)};
      7, 8: return {GrpLoad, x, nn};
      9, 10: return {GrpAdd, x, nn};
      11: return {GrpSys, 12'($urandom)};
      default: return {4'($urandom_range(8, 15)), 12'($urandom)};
    endcase
  endfunction

  initial begin : stimulus
    logic [11:0] wa;
    int          k;
    int          kind;

    vm_reset();

    // directed opening
    push_cmd(FuncExec, 12'h000, 8'h00);   // all-zero word at the reset pc: unknown
    push_cmd(FuncMemRd, 12'h000, 8'hFF);  // first font byte
    push_cmd(FuncRegRd, 12'hFFF, 8'h00);  // register index from the low nibble only
    run_op(OpRet);                        // return on an empty stack, pointer wraps
    run_op(OpCls);
    run_op({GrpJump, 12'hFFF});           // park pc on the last byte
    run_op({GrpLoad, 4'h0, 8'hFF});       // fetch straddles the top of memory
    run_op({GrpAdd, 4'h0, 8'h01});        // add wraps to zero
    run_op({GrpSkipEq, 4'h0, 8'h00});     // taken skip
    run_op({GrpSkipReg, 4'h1, 4'h2, 4'hF}); // nonzero low nibble still skips

    // random part, planned chunk by chunk from the predicted state
    while (n_pushed < RandItems) begin
      settle();
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        // short program laid down at pc, then run for a few steps
        k = $urandom_range(1, 4);
        wa = vm_pc;
        repeat (k) begin
          write_op(wa, rand_op());
          wa = wa + 12'd2;
        end
        repeat ($urandom_range(1, k + 2)) begin
          push_cmd(FuncExec, 12'($urandom), 8'($urandom));
          if ($urandom_range(0, 5) == 0)
            push_cmd(FuncRegRd, 12'($urandom), 8'($urandom));
        end
      end else if (kind == 5) begin
        // call to itself, repeated up to 20 times: can fill and wrap the return stack
        write_op(vm_pc, {GrpCall, vm_pc});
        repeat ($urandom_range(1, 20)) push_cmd(FuncExec, 12'($urandom), 8'($urandom));
      end else if (kind == 6) begin
        repeat ($urandom_range(1, 6)) run_op(OpRet);
      end else if (kind == 7) begin
        // half-written instruction
        push_cmd(FuncMemWr, vm_pc + 12'($urandom_range(0, 1)), 8'($urandom));
        push_cmd(FuncExec, 12'($urandom), 8'($urandom));
      end else begin
        // noise across all functions and all address and data bits
        repeat ($urandom_range(4, 12))
          push_cmd(func_e'($urandom_range(0, 3)), 12'($urandom), 8'($urandom));
      end
    end

    // drain: everything sent, every result back, then a short tail for strays
    settle();
    while (vm_results_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (n_errors == 0) begin
      $display("retro_vm_instruction_step_tb: done, clean");
    end else begin
      $display("retro_vm_instruction_step_tb: done, errors");
    end
    $finish;
  end

endmodule

/* retro_vm_instruction_step.f */
sv/rvis_pkg.sv
sv/retro_vm_instruction_step.sv
bench/retro_vm_instruction_step_tb.sv
